// ----- rtl/tdp_pkg.sv -----
// ----------------------------------------------------------------------------
// tdp_pkg
// shared types and constants for the trial division primality unit
// ----------------------------------------------------------------------------
`default_nettype none

package tdp_pkg;

    // width of the candidate port, fixed by the interface
    localparam int CAND_WIDTH = 32;

    // first trial divisor and its square
    localparam int FIRST_DIVISOR = 2;
    localparam int FIRST_SQUARE  = 4;

    // status returned by the remainder unit to the sequencer
    typedef struct packed {
        logic done;
        logic zero;
    } rem_status_t;

endpackage

`default_nettype wire

// ----- rtl/tdp_rem_unit.sv -----
// ----------------------------------------------------------------------------
// tdp_rem_unit
// iterative restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module tdp_rem_unit #(
    parameter int WIDTH = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [WIDTH-1:0]   dividend,
    input  wire logic [WIDTH-1:0]   divisor,
    output tdp_pkg::rem_status_t    status
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] rem_next;
    logic [WIDTH-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [WIDTH:0]   trial;

    // shift in the next dividend bit and subtract if it fits
    always_comb
    begin
        trial = {rem_reg, quo_reg[WIDTH-1]};
        if (trial >= {1'b0, divisor})
        begin
            rem_next = WIDTH'(trial - {1'b0, divisor});
        end
        else
        begin
            rem_next = trial[WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(WIDTH);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[WIDTH-2:0], 1'b0};
        end
    end

    assign status.done = done_reg;
    assign status.zero = (rem_reg == '0);

endmodule

`default_nettype wire

// ----- rtl/trial_division_primality_unit.sv -----
// ----------------------------------------------------------------------------
// trial_division_primality_unit
// primality test by trial division over divisors 2 .. floor(sqrt(n))
// ----------------------------------------------------------------------------
// sequence: for n below 4, ST_CHECK gives the result with no division;
// otherwise ST_CHECK and ST_DIV alternate over the trial divisors, up to
// (floor(sqrt(n)) - 1) of them, each tested by the one shared bit-serial
// remainder unit
// throughput: one item at a time, in_ready only while idle
// reset: asynchronous, clears the sequencer and valid flags
`default_nettype none

module trial_division_primality_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [tdp_pkg::CAND_WIDTH-1:0]  candidate,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 is_prime
);

    localparam int IN_BITS = (VALUE_WIDTH < tdp_pkg::CAND_WIDTH) ?
                             VALUE_WIDTH : tdp_pkg::CAND_WIDTH;
    localparam int SQ_W    = VALUE_WIDTH + 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                  state_reg;
    logic                    start_reg;
    logic                    prime_reg;
    logic [VALUE_WIDTH-1:0]  n_reg;
    logic [VALUE_WIDTH-1:0]  d_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic [SQ_W-1:0]         sq_next;
    tdp_pkg::rem_status_t    rem_status;

    // (d+1)^2 = d^2 + 2d + 1
    assign sq_next = sq_reg + (SQ_W'(d_reg) << 1) + SQ_W'(1);

    tdp_rem_unit #(
        .WIDTH (VALUE_WIDTH)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .dividend (n_reg),
        .divisor  (d_reg),
        .status   (rem_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            start_reg <= 1'b0;
            prime_reg <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    if (n_reg < VALUE_WIDTH'(tdp_pkg::FIRST_DIVISOR))
                    begin
                        prime_reg <= 1'b0;
                        state_reg <= ST_DONE;
                    end
                    else if (sq_reg > SQ_W'(n_reg))
                    begin
                        // no divisor left up to the square root
                        prime_reg <= 1'b1;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        start_reg <= 1'b1;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (rem_status.done)
                    begin
                        if (rem_status.zero)
                        begin
                            prime_reg <= 1'b0;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_CHECK;
                        end
                    end
                end
                ST_DONE:
                begin
                    if (out_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            n_reg  <= VALUE_WIDTH'(candidate[IN_BITS-1:0]);
            d_reg  <= VALUE_WIDTH'(tdp_pkg::FIRST_DIVISOR);
            sq_reg <= SQ_W'(tdp_pkg::FIRST_SQUARE);
        end
        else if (state_reg == ST_DIV && rem_status.done && !rem_status.zero)
        begin
            d_reg  <= d_reg + 1'b1;
            sq_reg <= sq_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_DONE);
    assign is_prime  = prime_reg;

endmodule

`default_nettype wire
